// File: rtl/ddo_pkg.sv
// shared types, constants and tables for the differential drive odometry block
package ddo_pkg;

	localparam int unsigned TABLE_IDX_W = 5;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

	localparam logic REG_DIST_PER_TICK = 1'b0;
	localparam logic REG_TURN_PER_DIST = 1'b1;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef struct packed {
		logic               command;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
		logic signed [47:0] new_x;
		logic signed [47:0] new_y;
		logic        [31:0] new_heading;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] pose_x;
		logic signed [47:0] pose_y;
		logic        [31:0] pose_heading;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_L,
		ST_MUL_H,
		ST_CINIT,
		ST_CSTEP,
		ST_TRIG,
		ST_PART0,
		ST_PART1,
		ST_ADD,
		ST_HEAD,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_MUL_A,
		DP_MUL_L,
		DP_MUL_H,
		DP_CINIT,
		DP_CSTEP,
		DP_TRIG,
		DP_PART0,
		DP_PART1,
		DP_ADD,
		DP_HEAD,
		DP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t                 op;
		logic                   axis;
		logic [TABLE_IDX_W-1:0] step;
	} dp_cmd_t;

	// arctangent of 2^-i in binary angle units
	function automatic logic [31:0] atan_bam(input logic [TABLE_IDX_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/ddo_ctrl.sv
// sequencing state machine for the odometry datapath
module ddo_ctrl #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_command,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output ddo_pkg::dp_cmd_t cmd
);
	import ddo_pkg::*;

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] step_q, step_d;
	logic          axis_q, axis_d;
	logic          out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			axis_q      <= axis_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		axis_d      = axis_q;
		out_valid_d = out_valid_q && out_stall;
		cmd.op      = DP_NONE;
		cmd.axis    = axis_q;
		cmd.step    = TABLE_IDX_W'(step_q);
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = DP_ACCEPT;
					state_d = (in_command == CMD_LOAD) ? ST_DONE : ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.op  = DP_MUL_A;
				state_d = ST_MUL_L;
			end
			ST_MUL_L: begin
				cmd.op  = DP_MUL_L;
				state_d = ST_MUL_H;
			end
			ST_MUL_H: begin
				cmd.op  = DP_MUL_H;
				state_d = ST_CINIT;
			end
			ST_CINIT: begin
				cmd.op  = DP_CINIT;
				step_d  = '0;
				state_d = ST_CSTEP;
			end
			ST_CSTEP: begin
				cmd.op = DP_CSTEP;
				step_d = step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					axis_d  = 1'b0;
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: begin
				cmd.op  = DP_TRIG;
				state_d = ST_PART0;
			end
			ST_PART0: begin
				cmd.op  = DP_PART0;
				state_d = ST_PART1;
			end
			ST_PART1: begin
				cmd.op  = DP_PART1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.op = DP_ADD;
				axis_d = 1'b1;
				// x first, then the same steps again for y
				state_d = axis_q ? ST_HEAD : ST_TRIG;
			end
			ST_HEAD: begin
				cmd.op  = DP_HEAD;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op      = DP_RESULT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/ddo_datapath.sv
// pose state, shared multiplier, cordic rotator and result register
module ddo_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ddo_pkg::dp_cmd_t  cmd,
	input  ddo_pkg::in_item_t in_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output ddo_pkg::out_item_t out_data
);
	import ddo_pkg::*;

	logic [31:0]        dpt_q, tpd_q;
	logic signed [47:0] x_q, y_q;
	logic [31:0]        heading_q;
	logic [31:0]        prev_l_q, prev_r_q;
	logic signed [33:0] diff_q, sum_q;
	logic [63:0]        a_q, l_q, mt_q;
	logic [31:0]        dth_q;
	logic               flip_q, neg_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [65:0]        p0_q;
	logic signed [49:0] step_q;
	out_item_t          res_q;

	logic signed [35:0] mul_a, mul_b;
	logic signed [71:0] mul_p;
	logic signed [32:0] dl, dr;
	logic [33:0]        ms;
	logic [31:0]        half, angle, angle_q1, folded;
	logic signed [33:0] t_sel, t_flip, xs, ys;
	logic [33:0]        t_mag;
	logic [97:0]        prod;
	logic [66:0]        mag;
	logic signed [49:0] mag_s;
	logic signed [47:0] pos_sel;
	logic signed [49:0] pos_sum;
	logic signed [47:0] pos_sat;
	logic [31:0]        atan_v;

	assign dl = 33'(in_data.left_count) - 33'(signed'(prev_l_q));
	assign dr = 33'(in_data.right_count) - 33'(signed'(prev_r_q));
	assign ms = sum_q[33] ? 34'(-sum_q) : 34'(sum_q);

	assign half     = {dth_q[31], dth_q[31:1]};
	assign angle    = heading_q + half;
	assign angle_q1 = angle + 32'h4000_0000;
	assign folded   = angle_q1[31] ? angle + 32'h8000_0000 : angle;

	assign t_sel  = cmd.axis ? cy_q : cx_q;
	assign t_flip = flip_q ? -t_sel : t_sel;
	assign t_mag  = t_flip[33] ? 34'(-t_flip) : 34'(t_flip);

	assign xs     = cx_q >>> cmd.step;
	assign ys     = cy_q >>> cmd.step;
	assign atan_v = atan_bam(cmd.step);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_MUL_A: begin
				mul_a = 36'(diff_q);
				mul_b = {4'b0, dpt_q};
			end
			DP_MUL_L: begin
				mul_a = {4'b0, a_q[31:0]};
				mul_b = {4'b0, tpd_q};
			end
			DP_MUL_H: begin
				mul_a = {4'b0, a_q[63:32]};
				mul_b = {4'b0, tpd_q};
			end
			DP_TRIG: begin
				mul_a = {2'b0, t_mag};
				mul_b = {4'b0, dpt_q};
			end
			DP_PART0: begin
				mul_a = {2'b0, ms};
				mul_b = {4'b0, mt_q[31:0]};
			end
			DP_PART1: begin
				mul_a = {2'b0, ms};
				mul_b = {4'b0, mt_q[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// full magnitude product, scaled down by 2^31 and clamped to 2^48
	assign prod  = {32'b0, p0_q} + {mul_p[65:0], 32'b0};
	assign mag   = prod[97:31];
	assign mag_s = (mag > 67'h1_0000_0000_0000) ? 50'sh1_0000_0000_0000 : signed'(mag[49:0]);

	assign pos_sel = cmd.axis ? y_q : x_q;
	assign pos_sum = 50'(pos_sel) + step_q;
	always_comb begin
		if (pos_sum > 50'(POS_MAX))
			pos_sat = POS_MAX;
		else if (pos_sum < 50'(POS_MIN))
			pos_sat = POS_MIN;
		else
			pos_sat = pos_sum[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q     <= 32'd65536;
			tpd_q     <= 32'd65536;
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
			prev_l_q  <= '0;
			prev_r_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DIST_PER_TICK)
					dpt_q <= cfg_data;
				if (cfg_index == REG_TURN_PER_DIST)
					tpd_q <= cfg_data;
			end
			case (cmd.op)
				DP_ACCEPT: begin
					if (in_data.command == CMD_LOAD) begin
						x_q       <= in_data.new_x;
						y_q       <= in_data.new_y;
						heading_q <= in_data.new_heading;
					end else begin
						prev_l_q <= in_data.left_count;
						prev_r_q <= in_data.right_count;
					end
				end
				DP_ADD: begin
					if (cmd.axis)
						y_q <= pos_sat;
					else
						x_q <= pos_sat;
				end
				DP_HEAD: heading_q <= heading_q + dth_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_ACCEPT: begin
				diff_q <= 34'(dr) - 34'(dl);
				sum_q  <= 34'(dr) + 34'(dl);
			end
			DP_MUL_A: a_q <= mul_p[63:0];
			DP_MUL_L: l_q <= mul_p[63:0];
			DP_MUL_H: dth_q <= l_q[63:32] + mul_p[31:0];
			DP_CINIT: begin
				flip_q <= angle_q1[31];
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				cz_q   <= 34'(signed'(folded));
			end
			DP_CSTEP: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - 34'(atan_v);
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + 34'(atan_v);
				end
			end
			DP_TRIG: begin
				mt_q  <= mul_p[63:0];
				neg_q <= sum_q[33] ^ t_flip[33];
			end
			DP_PART0: p0_q <= mul_p[65:0];
			DP_PART1: step_q <= neg_q ? -mag_s : mag_s;
			DP_RESULT: begin
				res_q.pose_x       <= x_q;
				res_q.pose_y       <= y_q;
				res_q.pose_heading <= heading_q;
			end
			default: ;
		endcase
	end

	assign out_data = res_q;

endmodule

// File: rtl/differential_drive_odometry.sv
// an encoder update runs the multiplies, the CORDIC_STEPS cordic iterations and the x and y
// steps before its earliest result beat; a pose load goes straight to the result; one item at
// a time, so the next beat is taken only once the last is through, set by the shared multiplier
// and the single cordic stage, which iterates once per cycle
// the finished pose sits in an output register, so the next beat is taken while it waits
// reset clears the pose and stored counts and loads both scale registers with 65536
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ddo_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ddo_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);
	import ddo_pkg::*;

	dp_cmd_t cmd;

	ddo_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_command(in_data.command),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ddo_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule
